// ----- sv/aes_pkg.sv -----
// ----------------------------------------------------------------------------
// AES package
// Shared constants, lookup tables and round functions of the AES-128 engine.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

   localparam int MAX_ROUNDS = 14;
   localparam int STAGES     = MAX_ROUNDS + 1;

   typedef logic [127:0]      block_type;
   typedef logic [255:0][7:0] sbox_tab_type;

   typedef enum logic [1:0] {
      CSR_KEY_HIGH    = 2'd0,
      CSR_KEY_LOW     = 2'd1,
      CSR_ROUND_COUNT = 2'd2
   } csr_index_type;

   // Multiplication by x in GF(2^8) with modulus 0x11B.
   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] x;
      acc = 8'h00;
      x   = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc = acc ^ x;
         x = xtime(x);
      end
      return acc;
   endfunction

   // Only evaluated while the tables are built.
   function automatic logic [7:0] ginv(input logic [7:0] a);
      logic [7:0] r;
      r = 8'h01;
      for (int i = 0; i < 254; i++) r = gmul(r, a);
      return r;
   endfunction

   function automatic logic [7:0] rotl(input logic [7:0] v, input int n);
      return 8'((v << n) | (v >> (8 - n)));
   endfunction

   function automatic logic [7:0] sbox_calc(input logic [7:0] b);
      logic [7:0] x;
      x = ginv(b);
      return x ^ rotl(x, 1) ^ rotl(x, 2) ^ rotl(x, 3) ^ rotl(x, 4) ^ 8'h63;
   endfunction

   function automatic sbox_tab_type build_sbox();
      sbox_tab_type t;
      for (int i = 0; i < 256; i++) t[i] = sbox_calc(8'(i));
      return t;
   endfunction

   function automatic sbox_tab_type build_inv_sbox();
      sbox_tab_type t;
      for (int i = 0; i < 256; i++) t[sbox_calc(8'(i))] = 8'(i);
      return t;
   endfunction

   localparam sbox_tab_type SBOX_TAB     = build_sbox();
   localparam sbox_tab_type INV_SBOX_TAB = build_inv_sbox();

   function automatic logic [7:0] get_byte(input block_type s, input int i);
      return s[127 - 8 * i -: 8];
   endfunction

   // Row shift and byte substitution in one pass; both are bytewise so they commute.
   function automatic block_type sub_shift(input block_type s, input logic dec);
      block_type  t;
      logic [1:0] src;
      logic [7:0] b;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            src = dec ? 2'(c - r) : 2'(c + r);
            b   = get_byte(s, int'(src) * 4 + r);
            t[127 - 8 * (c * 4 + r) -: 8] = dec ? INV_SBOX_TAB[b] : SBOX_TAB[b];
         end
      end
      return t;
   endfunction

   function automatic logic [7:0] mix_coef(input logic [1:0] idx, input logic dec);
      logic [7:0] v;
      case (idx)
         2'd0:    v = dec ? 8'd14 : 8'd2;
         2'd1:    v = dec ? 8'd11 : 8'd3;
         2'd2:    v = dec ? 8'd13 : 8'd1;
         default: v = dec ? 8'd9  : 8'd1;
      endcase
      return v;
   endfunction

   function automatic block_type mix_columns(input block_type s, input logic dec);
      block_type  t;
      logic [7:0] acc;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            acc = 8'h00;
            for (int k = 0; k < 4; k++)
               acc = acc ^ gmul(mix_coef(2'(k - r), dec), get_byte(s, c * 4 + k));
            t[127 - 8 * (c * 4 + r) -: 8] = acc;
         end
      end
      return t;
   endfunction

   // Next four key words of the AES-128 schedule.
   function automatic block_type next_round_key(input block_type k, input logic [7:0] rcon);
      logic [31:0] w0, w1, w2, w3, tmp;
      w0  = k[127:96];
      w1  = k[95:64];
      w2  = k[63:32];
      w3  = k[31:0];
      tmp = {SBOX_TAB[w3[23:16]] ^ rcon, SBOX_TAB[w3[15:8]],
             SBOX_TAB[w3[7:0]], SBOX_TAB[w3[31:24]]};
      w0  = w0 ^ tmp;
      w1  = w1 ^ w0;
      w2  = w2 ^ w1;
      w3  = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

endpackage

`default_nettype wire

// ----- sv/aes128_block_cipher.sv -----
// ----------------------------------------------------------------------------
// AES-128 block cipher
// Fully unrolled encrypt/decrypt pipeline with a configurable round count.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Content
//  req_      in         req_valid/req_ready    kind, data_high, data_low
//  rsp_      out        rsp_valid/rsp_ready    result_high, result_low
//  csr_      in         csr_we                 key_high, key_low, round_count
//
// One block enters per cycle while no stall or key rebuild holds it off.
// There are 15 register stages: the initial key-add stage plus fourteen
// round stages; a block passes through them in order to the rsp_ outputs.
// Rounds beyond the configured count pass the block through unchanged.
// After reset and after every register write the round keys are rebuilt by
// a sequential key-schedule unit, one round key per cycle;
// req_ready stays low meanwhile. Each stage holds when the stage after it is
// full and stalled, so a stall at the output loses and repeats nothing.
`default_nettype none

module aes128_block_cipher
   import aes_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_kind,
   input  wire logic [63:0] req_data_high,
   input  wire logic [63:0] req_data_low,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_result_high,
   output logic [63:0]      rsp_result_low,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   // Configuration registers.
   logic [63:0] key_high_ff, key_low_ff;
   logic [3:0]  round_count_ff;
   logic [3:0]  rounds;

   // Key schedule. Encryption keys sit at their round index; decryption keys
   // are stored reversed so each stage reads one fixed register.
   block_type   enc_key_ff [STAGES];
   block_type   dec_key_ff [STAGES];
   block_type   cur_key_ff;
   logic [7:0]  rcon_ff;
   logic [3:0]  kcnt_ff;
   logic        busy_ff, restart_ff;
   logic [3:0]  dec_slot;

   // Pipeline stages.
   block_type   st_data_ff [STAGES];
   block_type   st_data_in [STAGES];
   logic        st_kind_ff [STAGES];
   logic        st_valid_ff[STAGES];
   logic        st_ready   [STAGES + 1];

   // A round count of zero runs one round and fifteen runs fourteen.
   always_comb begin
      if (round_count_ff == 4'd0)
         rounds = 4'd1;
      else if (round_count_ff > 4'(MAX_ROUNDS))
         rounds = 4'(MAX_ROUNDS);
      else
         rounds = round_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff    <= '0;
         key_low_ff     <= '0;
         round_count_ff <= 4'd10;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KEY_HIGH:    key_high_ff    <= csr_wdata;
            CSR_KEY_LOW:     key_low_ff     <= csr_wdata;
            CSR_ROUND_COUNT: round_count_ff <= csr_wdata[3:0];
            default:         ;
         endcase
      end
   end

   assign dec_slot = rounds - kcnt_ff;

   // The schedule restarts on any write; the block is idle then by contract.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         restart_ff <= 1'b1;
         kcnt_ff    <= '0;
      end else if (csr_we) begin
         busy_ff    <= 1'b1;
         restart_ff <= 1'b1;
      end else if (restart_ff) begin
         restart_ff <= 1'b0;
         kcnt_ff    <= '0;
      end else if (busy_ff) begin
         if (kcnt_ff == 4'(MAX_ROUNDS))
            busy_ff <= 1'b0;
         else
            kcnt_ff <= kcnt_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (restart_ff) begin
         cur_key_ff <= {key_high_ff, key_low_ff};
         rcon_ff    <= 8'h01;
      end else if (busy_ff) begin
         cur_key_ff                <= next_round_key(cur_key_ff, rcon_ff);
         rcon_ff                   <= xtime(rcon_ff);
         enc_key_ff[kcnt_ff]       <= cur_key_ff;
         if (kcnt_ff <= rounds)
            dec_key_ff[dec_slot]   <= cur_key_ff;
      end
   end

   // Stage 0 takes the transfer and adds the first key of its direction.
   // Stage s then runs round s for encryption or the s-th inverse round.
   always_comb begin
      block_type ss, tmp;
      logic      last;
      st_data_in[0] = {req_data_high, req_data_low} ^
                      (req_kind ? dec_key_ff[0] : enc_key_ff[0]);
      for (int s = 1; s < STAGES; s++) begin
         ss   = sub_shift(st_data_ff[s - 1], st_kind_ff[s - 1]);
         tmp  = ss;
         last = (4'(s) == rounds);
         if (4'(s) > rounds) begin
            st_data_in[s] = st_data_ff[s - 1];
         end else if (!st_kind_ff[s - 1]) begin
            tmp           = last ? ss : mix_columns(ss, 1'b0);
            st_data_in[s] = tmp ^ enc_key_ff[s];
         end else begin
            tmp           = ss ^ dec_key_ff[s];
            st_data_in[s] = last ? tmp : mix_columns(tmp, 1'b1);
         end
      end
   end

   // A stage moves when it is empty or the stage after it moves.
   always_comb begin
      st_ready[STAGES] = rsp_ready;
      for (int s = STAGES - 1; s >= 0; s--)
         st_ready[s] = !st_valid_ff[s] || st_ready[s + 1];
   end

   assign req_ready = st_ready[0] && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGES; s++) st_valid_ff[s] <= 1'b0;
      end else begin
         if (st_ready[0]) st_valid_ff[0] <= req_valid && req_ready;
         for (int s = 1; s < STAGES; s++)
            if (st_ready[s]) st_valid_ff[s] <= st_valid_ff[s - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (st_ready[0]) begin
         st_data_ff[0] <= st_data_in[0];
         st_kind_ff[0] <= req_kind;
      end
      for (int s = 1; s < STAGES; s++) begin
         if (st_ready[s]) begin
            st_data_ff[s] <= st_data_in[s];
            st_kind_ff[s] <= st_kind_ff[s - 1];
         end
      end
   end

   assign rsp_valid       = st_valid_ff[STAGES - 1];
   assign rsp_result_high = st_data_ff[STAGES - 1][127:64];
   assign rsp_result_low  = st_data_ff[STAGES - 1][63:0];

   // The schedule counter never runs past the last round key.
   a_kcnt_range: assert property (@(posedge clock) disable iff (reset)
      kcnt_ff <= 4'(MAX_ROUNDS)) else $error("key counter out of range");

   // A restart always leaves the schedule busy.
   a_restart_busy: assert property (@(posedge clock) disable iff (reset)
      restart_ff |-> busy_ff) else $error("restart without busy");

   // A full middle stage that is blocked keeps its item.
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      st_valid_ff[7] && !st_ready[7] |=> st_valid_ff[7] && $stable(st_data_ff[7]))
      else $error("stalled stage lost its item");

   // No transfer while round keys are being rebuilt.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> !st_valid_ff[0] || $stable(st_data_ff[0]) || $past(!busy_ff))
      else $error("item entered during key schedule");

endmodule

`default_nettype wire

// ----- dv/aes128_block_cipher_tb.sv -----
// ----------------------------------------------------------------------------
// AES-128 block cipher testbench
// Drives blocks through the cipher under several keys and round counts, and
// compares each result with an in-bench AES computation of the same block.
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_block_cipher_tb
   import aes_pkg::*;
();

   // One input transfer as the driver sees it.
   typedef struct {
      logic        kind;
      logic [63:0] data_high;
      logic [63:0] data_low;
   } cipher_req_type;

   typedef struct {
      logic [63:0] result_high;
      logic [63:0] result_low;
   } cipher_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_kind;
   logic [63:0] req_data_high;
   logic [63:0] req_data_low;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_result_high;
   logic [63:0] rsp_result_low;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [63:0] csr_wdata;

   aes128_block_cipher i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_data_high   (req_data_high),
      .req_data_low    (req_data_low),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_high (rsp_result_high),
      .rsp_result_low  (rsp_result_low),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // Blocks waiting to be driven, and the ciphertexts or plaintexts that the
   // block is expected to return, oldest first.
   cipher_req_type pending_blocks[$];
   cipher_rsp_type expected_blocks[$];

   // Bench copy of the configuration registers.
   logic [63:0] key_high_q;
   logic [63:0] key_low_q;
   logic [3:0]  rounds_q;

   // Idle percentages of the sender and the receiver.
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   bit          hold_sender;
   int unsigned error_count;
   longint unsigned cycle_count;

   // Transfer seen at the last rising edge.
   logic req_ready_seen;

   localparam longint unsigned CYCLE_LIMIT = 400000;

   // ------------------------------------------------------------------------
   // GF(2^8) arithmetic and the S-box, computed from first principles.
   // ------------------------------------------------------------------------
   function automatic logic [7:0] gf_dbl(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc ^= a;
         a = gf_dbl(a);
      end
      return acc;
   endfunction

   function automatic logic [7:0] gf_recip(input logic [7:0] a);
      logic [7:0] r;
      logic [7:0] base;
      r    = 8'h01;
      base = a;
      for (int e = 254; e != 0; e >>= 1) begin
         if (e & 1) r = gf_times(r, base);
         base = gf_times(base, base);
      end
      return r;
   endfunction

   function automatic logic [7:0] rol8(input logic [7:0] v, input int n);
      return (v << n) | (v >> (8 - n));
   endfunction

   logic [7:0] fwd_sbox[256];
   logic [7:0] inv_sbox[256];

   initial begin
      logic [7:0] x;
      for (int i = 0; i < 256; i++) begin
         x = gf_recip(8'(i));
         fwd_sbox[i] = x ^ rol8(x, 1) ^ rol8(x, 2) ^ rol8(x, 3) ^ rol8(x, 4) ^ 8'h63;
      end
      for (int i = 0; i < 256; i++) inv_sbox[fwd_sbox[i]] = 8'(i);
   end

   // ------------------------------------------------------------------------
   // AES state as 16 bytes; byte i sits at row i mod 4, column i div 4.
   // ------------------------------------------------------------------------
   typedef logic [7:0] aes_state_type[16];

   function automatic void mix_state(ref aes_state_type s, input bit inv);
      logic [7:0] col[4];
      logic [7:0] coef[4];
      logic [7:0] acc;
      if (inv) coef = '{8'd14, 8'd11, 8'd13, 8'd9};
      else     coef = '{8'd2, 8'd3, 8'd1, 8'd1};
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) col[r] = s[c*4 + r];
         for (int r = 0; r < 4; r++) begin
            acc = 8'h00;
            for (int k = 0; k < 4; k++) acc ^= gf_times(coef[(k - r + 4) % 4], col[k]);
            s[c*4 + r] = acc;
         end
      end
   endfunction

   // Row shift combined with byte substitution; both act on single bytes.
   function automatic void subshift_state(ref aes_state_type s, input bit inv);
      aes_state_type t;
      int src;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            src = inv ? (c - r + 4) % 4 : (c + r) % 4;
            t[c*4 + r] = inv ? inv_sbox[s[src*4 + r]] : fwd_sbox[s[src*4 + r]];
         end
      end
      s = t;
   endfunction

   function automatic cipher_rsp_type predict_cipher(input cipher_req_type item);
      logic [7:0]  round_keys[15][16];
      logic [7:0]  w[4];
      logic [7:0]  t;
      logic [7:0]  rc;
      logic [127:0] key;
      logic [127:0] blk;
      aes_state_type s;
      int          rounds;
      cipher_rsp_type res;
      rounds = rounds_q;
      // A zero round count acts as one round, fifteen saturates to fourteen.
      if (rounds < 1) rounds = 1;
      if (rounds > MAX_ROUNDS) rounds = MAX_ROUNDS;
      key = {key_high_q, key_low_q};
      blk = {item.data_high, item.data_low};
      for (int i = 0; i < 16; i++) begin
         round_keys[0][i] = key[127 - 8*i -: 8];
         s[i] = blk[127 - 8*i -: 8];
      end
      rc = 8'h01;
      for (int wi = 4; wi < 4*(rounds + 1); wi++) begin
         for (int j = 0; j < 4; j++) w[j] = round_keys[(wi - 1) / 4][((wi - 1) % 4)*4 + j];
         if (wi % 4 == 0) begin
            t    = w[0];
            w[0] = fwd_sbox[w[1]] ^ rc;
            w[1] = fwd_sbox[w[2]];
            w[2] = fwd_sbox[w[3]];
            w[3] = fwd_sbox[t];
            rc   = gf_dbl(rc);
         end
         for (int j = 0; j < 4; j++)
            round_keys[wi / 4][(wi % 4)*4 + j] = w[j] ^ round_keys[(wi - 4) / 4][(wi % 4)*4 + j];
      end
      if (!item.kind) begin
         for (int i = 0; i < 16; i++) s[i] ^= round_keys[0][i];
         for (int rd = 1; rd < rounds; rd++) begin
            subshift_state(s, 1'b0);
            mix_state(s, 1'b0);
            for (int i = 0; i < 16; i++) s[i] ^= round_keys[rd][i];
         end
         subshift_state(s, 1'b0);
         for (int i = 0; i < 16; i++) s[i] ^= round_keys[rounds][i];
      end else begin
         for (int i = 0; i < 16; i++) s[i] ^= round_keys[rounds][i];
         subshift_state(s, 1'b1);
         for (int rd = rounds - 1; rd > 0; rd--) begin
            for (int i = 0; i < 16; i++) s[i] ^= round_keys[rd][i];
            mix_state(s, 1'b1);
            subshift_state(s, 1'b1);
         end
         for (int i = 0; i < 16; i++) s[i] ^= round_keys[0][i];
      end
      for (int i = 0; i < 16; i++) blk[127 - 8*i -: 8] = s[i];
      res.result_high = blk[127:64];
      res.result_low  = blk[63:0];
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Clock, cycle limit.
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Driver: presents queued blocks on the falling edge. Valid is only
   // lowered after a transfer and only if the sender idles or has no block,
   // so a held block never changes before it is taken.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_ready_seen) begin
         // Hold the current block until it is taken.
      end else if (pending_blocks.size() != 0 && !hold_sender &&
                   $urandom_range(99) >= send_idle_pct) begin
         cipher_req_type item;
         item = pending_blocks.pop_front();
         req_valid     <= 1'b1;
         req_kind      <= item.kind;
         req_data_high <= item.data_high;
         req_data_low  <= item.data_low;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // The prediction is made at the transfer edge with the configuration in
   // force at that moment.
   always @(posedge clock) begin
      cipher_req_type item;
      req_ready_seen <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         item.kind      = req_kind;
         item.data_high = req_data_high;
         item.data_low  = req_data_low;
         expected_blocks = {expected_blocks, predict_cipher(item)};
      end
   end

   // Receiver readiness changes on the falling edge.
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else       rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // ------------------------------------------------------------------------
   // Monitor: checks every result transfer against the oldest prediction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      cipher_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_blocks.size() == 0) begin
            $error("result transfer with no block outstanding");
            error_count++;
         end else begin
            want = expected_blocks.pop_front();
            if (rsp_result_high !== want.result_high) begin
               $error("result_high expected %h actual %h", want.result_high, rsp_result_high);
               error_count++;
            end
            if (rsp_result_low !== want.result_low) begin
               $error("result_low expected %h actual %h", want.result_low, rsp_result_low);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------------
   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic queue_block(input logic kind, input logic [63:0] hi, input logic [63:0] lo);
      cipher_req_type item;
      item.kind      = kind;
      item.data_high = hi;
      item.data_low  = lo;
      pending_blocks = {pending_blocks, item};
   endtask

   // Waits until the driver is empty and every result is back, then lets the
   // pipeline drain fully before anything touches the registers.
   task automatic wait_quiet();
      while (pending_blocks.size() != 0 || req_valid || expected_blocks.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Register write, driven on the falling edge, with the bench copy
   // updated alongside. The round-count register holds only four bits.
   task automatic write_csr(input csr_index_type idx, input logic [63:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_KEY_HIGH:    key_high_q = value;
         CSR_KEY_LOW:     key_low_q  = value;
         CSR_ROUND_COUNT: rounds_q   = value[3:0];
         default: ;
      endcase
   endtask

   task automatic random_phase(input int count);
      for (int i = 0; i < count; i++)
         queue_block(1'($urandom_range(1)), rand64(), rand64());
      wait_quiet();
   endtask

   // ------------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------------
   initial begin
      cycle_count   = 0;
      error_count   = 0;
      hold_sender   = 1'b0;
      send_idle_pct = 20;
      recv_idle_pct = 46;
      key_high_q    = '0;
      key_low_q     = '0;
      rounds_q      = 4'd10;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_kind      = 1'b0;
      req_data_high = '0;
      req_data_low  = '0;
      rsp_ready     = 1'b0;
      csr_we        = 1'b0;
      csr_index     = CSR_KEY_HIGH;
      csr_wdata     = '0;
      req_ready_seen = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed blocks under the reset key: extremes in both directions.
      queue_block(1'b0, '0, '0);
      queue_block(1'b1, '0, '0);
      queue_block(1'b0, '1, '1);
      queue_block(1'b1, '1, '1);
      queue_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
      wait_quiet();

      // Standard test key, then the round-count extremes, including zero
      // acting as one round and fifteen saturating to fourteen.
      write_csr(CSR_KEY_HIGH, 64'h0001020304050607);
      write_csr(CSR_KEY_LOW,  64'h08090a0b0c0d0e0f);
      for (int rc = 0; rc < 16; rc += 5) begin
         write_csr(CSR_ROUND_COUNT, 64'(rc));
         queue_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
         queue_block(1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
         queue_block(1'b0, 64'h8000000000000000, 64'h0000000000000001);
         wait_quiet();
      end
      write_csr(CSR_ROUND_COUNT, 64'd14);
      queue_block(1'b1, '1, '0);
      wait_quiet();

      // Random phases, each under a fresh key and round count; the sender is
      // held once until every result has come back.
      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 2) begin
            send_idle_pct = 46;
            recv_idle_pct = 20;
         end else if (ph == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_csr(CSR_KEY_HIGH, (ph == 1) ? '1 : rand64());
         write_csr(CSR_KEY_LOW,  (ph == 1) ? '1 : rand64());
         write_csr(CSR_ROUND_COUNT, {rand64()} | ((ph == 5) ? 64'hf : 64'h0));
         if (ph == 3) begin
            for (int i = 0; i < 100; i++)
               queue_block(1'($urandom_range(1)), rand64(), rand64());
            while (pending_blocks.size() != 0) @(posedge clock);
            hold_sender = 1'b1;
            while (req_valid || expected_blocks.size() != 0) @(posedge clock);
            hold_sender = 1'b0;
         end
         random_phase(ph == 3 ? 230 : 330);
      end

      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
